// ----- src/rc6tx_pkg.sv -----
package rc6tx_pkg;

	// Frame geometry.
	localparam int DATA_BITS  = 16;
	localparam int SEG_TOTAL  = 12 + 2 * DATA_BITS;
	localparam int IDX_W      = $clog2(SEG_TOTAL + 1);
	// Search candidates reach up to five places past the end marker.
	localparam int CAND_W     = $clog2(SEG_TOTAL + 6);
	localparam int DBIT_W     = (DATA_BITS > 1) ? $clog2(DATA_BITS) : 1;
	// First half of the toggle bit: leader mark, long space, start bit, three mode bits.
	localparam int TOGGLE_POS = 10;

	// Field widths.
	localparam int CODE_W     = 16;
	localparam int HALF_W     = 6;
	localparam int MARK_W     = 12;
	localparam int LEADER_W   = 13;
	localparam int SPACE_W    = 12;
	localparam int QUOT_W     = 9;
	localparam int LEN_W      = QUOT_W + HALF_W + 1;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 13;

	// Division by 27 as a multiplication by a scaled reciprocal.
	localparam int MARK_DIV     = 27;
	localparam int RECIP_27     = 9710;
	localparam int RECIP_SHIFT  = 18;
	localparam int RECIP_PROD_W = RECIP_SHIFT + QUOT_W;

	// Register reset values.
	localparam int HALF_RST        = 13;
	localparam int SHORT_MARK_RST  = 444;
	localparam int SHORT_SPACE_RST = 333;
	localparam int LEADER_MARK_RST = 2666;
	localparam int LONG_SPACE_RST  = 800;
	localparam int TOGGLE_MARK_RST = 889;

	localparam int SHORT_Q_RST  = SHORT_MARK_RST / MARK_DIV;
	localparam int LEADER_Q_RST = LEADER_MARK_RST / MARK_DIV;
	localparam int TOGGLE_Q_RST = TOGGLE_MARK_RST / MARK_DIV;

	localparam int SHORT_LEN_RST  = SHORT_Q_RST * 2 * HALF_RST;
	localparam int LEADER_LEN_RST = LEADER_Q_RST * 2 * HALF_RST;
	localparam int TOGGLE_LEN_RST = TOGGLE_Q_RST * 2 * HALF_RST;

	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	// Register indexes on the configuration port.
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_CARRIER_HALF = 3'd0,
		CFG_SHORT_MARK   = 3'd1,
		CFG_SHORT_SPACE  = 3'd2,
		CFG_LEADER_MARK  = 3'd3,
		CFG_LONG_SPACE   = 3'd4,
		CFG_TOGGLE_MARK  = 3'd5
	} cfg_reg_t;

	typedef enum logic {
		OP_TICK = 1'b0,
		OP_SEND = 1'b1
	} op_t;

	// Which length a segment takes.
	typedef enum logic [2:0] {
		LEN_LEADER      = 3'd0,
		LEN_SHORT_MARK  = 3'd1,
		LEN_TOGGLE_MARK = 3'd2,
		LEN_SHORT_SPACE = 3'd3,
		LEN_LONG_SPACE  = 3'd4
	} len_sel_t;

	typedef struct packed {
		op_t                  op;
		logic [DATA_BITS-1:0] data;
	} item_t;

	// Timing values as the transmitter uses them, mark lengths already quantized.
	typedef struct packed {
		logic [HALF_W-1:0]  half;
		logic [LEN_W-1:0]   leader_len;
		logic [LEN_W-1:0]   short_mark_len;
		logic [LEN_W-1:0]   toggle_mark_len;
		logic [SPACE_W-1:0] short_space;
		logic [SPACE_W-1:0] long_space;
	} cfg_t;

	// Length class of the segment at a position; valid for positions below SEG_TOTAL.
	function automatic len_sel_t seg_sel(input logic [CAND_W-1:0] pos, input logic tgl,
			input logic [DATA_BITS-1:0] data);
		logic [CAND_W-1:0] j;
		logic [CAND_W-1:0] slot;
		logic [DBIT_W-1:0] bi;
		logic              v;
		logic              mark;
		len_sel_t          sel;
		j    = pos - CAND_W'(2);
		slot = j >> 1;
		bi   = DBIT_W'(CAND_W'(DATA_BITS + 4) - slot);
		v    = 1'b0;
		if (pos == CAND_W'(0)) begin
			sel = LEN_LEADER;
		end else if (pos == CAND_W'(1)) begin
			sel = LEN_LONG_SPACE;
		end else begin
			if (slot == CAND_W'(0)) begin
				v = 1'b1;
			end else if (slot <= CAND_W'(3)) begin
				v = 1'b0;
			end else if (slot == CAND_W'(4)) begin
				v = tgl;
			end else begin
				v = data[bi];
			end
			// A one is mark then space, a zero is space then mark.
			mark = j[0] ? ~v : v;
			if (slot == CAND_W'(4)) begin
				sel = mark ? LEN_TOGGLE_MARK : LEN_LONG_SPACE;
			end else begin
				sel = mark ? LEN_SHORT_MARK : LEN_SHORT_SPACE;
			end
		end
		return sel;
	endfunction

endpackage

// ----- src/rc6tx_if.sv -----
// Input channel: one tick or send command per beat.
interface rc6tx_item_if import rc6tx_pkg::*; ();
	logic              valid;
	logic              ready;
	logic              command;
	logic [CODE_W-1:0] code;

	modport source(output valid, command, code, input ready);
	modport sink(input valid, command, code, output ready);
endinterface

// Output channel: one result per beat.
interface rc6tx_result_if import rc6tx_pkg::*; ();
	logic valid;
	logic ready;
	logic pin_level;
	logic busy_res;
	logic frame_end;
	logic rejected;

	modport source(output valid, pin_level, busy_res, frame_end, rejected, input ready);
	modport sink(input valid, pin_level, busy_res, frame_end, rejected, output ready);
endinterface

// ----- src/rc6tx_cfg.sv -----
module rc6tx_cfg import rc6tx_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	output cfg_t                  cfg
);

	logic [HALF_W-1:0]       half_q;
	logic [SPACE_W-1:0]      short_space_q;
	logic [SPACE_W-1:0]      long_space_q;
	logic [QUOT_W-1:0]       short_q_q;
	logic [QUOT_W-1:0]       leader_q_q;
	logic [QUOT_W-1:0]       toggle_q_q;
	logic [LEN_W-1:0]        short_len_q;
	logic [LEN_W-1:0]        leader_len_q;
	logic [LEN_W-1:0]        toggle_len_q;
	logic [LEADER_W-1:0]     nominal;
	logic [RECIP_PROD_W-1:0] recip_prod;
	logic [QUOT_W-1:0]       quot;
	logic [LEN_W-1:0]        period;

	// The leader register is one bit wider than the other mark registers.
	assign nominal = (cfg_index == CFG_LEADER_MARK) ? cfg_wdata[LEADER_W-1:0]
		: {1'b0, cfg_wdata[MARK_W-1:0]};

	// Carrier periods per mark, floor(nominal / 27), taken once at the write.
	assign recip_prod = RECIP_PROD_W'(nominal) * RECIP_PROD_W'(RECIP_27);
	assign quot       = recip_prod[RECIP_SHIFT +: QUOT_W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			half_q        <= HALF_W'(HALF_RST);
			short_space_q <= SPACE_W'(SHORT_SPACE_RST);
			long_space_q  <= SPACE_W'(LONG_SPACE_RST);
			short_q_q     <= QUOT_W'(SHORT_Q_RST);
			leader_q_q    <= QUOT_W'(LEADER_Q_RST);
			toggle_q_q    <= QUOT_W'(TOGGLE_Q_RST);
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_CARRIER_HALF: half_q        <= cfg_wdata[HALF_W-1:0];
				CFG_SHORT_MARK:   short_q_q     <= quot;
				CFG_SHORT_SPACE:  short_space_q <= cfg_wdata[SPACE_W-1:0];
				CFG_LEADER_MARK:  leader_q_q    <= quot;
				CFG_LONG_SPACE:   long_space_q  <= cfg_wdata[SPACE_W-1:0];
				CFG_TOGGLE_MARK:  toggle_q_q    <= quot;
				default: ;
			endcase
		end
	end

	// Mark lengths in ticks, registered from their source registers in the cycle after.
	assign period = LEN_W'({half_q, 1'b0});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			short_len_q  <= LEN_W'(SHORT_LEN_RST);
			leader_len_q <= LEN_W'(LEADER_LEN_RST);
			toggle_len_q <= LEN_W'(TOGGLE_LEN_RST);
		end else begin
			short_len_q  <= LEN_W'(short_q_q) * period;
			leader_len_q <= LEN_W'(leader_q_q) * period;
			toggle_len_q <= LEN_W'(toggle_q_q) * period;
		end
	end

	assign cfg.half            = half_q;
	assign cfg.leader_len      = leader_len_q;
	assign cfg.short_mark_len  = short_len_q;
	assign cfg.toggle_mark_len = toggle_len_q;
	assign cfg.short_space     = short_space_q;
	assign cfg.long_space      = long_space_q;

endmodule

// ----- src/rc6tx_front.sv -----
module rc6tx_front import rc6tx_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	rc6tx_item_if.sink   items,
	input  logic         queue_full,
	output logic         push,
	output item_t        push_item
);

	logic  valid_s1;
	item_t item_s1;
	logic  accept;

	// A held beat leaves as soon as the queue has room.
	assign push        = valid_s1 && !queue_full;
	assign items.ready = !valid_s1 || !queue_full;
	assign accept      = items.valid && items.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (push) begin
			valid_s1 <= 1'b0;
		end
	end

	// Classify the beat; code bits above the data width are dropped here.
	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1.op   <= items.command ? OP_SEND : OP_TICK;
			item_s1.data <= DATA_BITS'(items.code);
		end
	end

	assign push_item = item_s1;

endmodule

// ----- src/rc6tx_queue.sv -----
module rc6tx_queue import rc6tx_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  item_t push_item,
	output logic  full,
	input  logic  pop,
	output logic  head_valid,
	output item_t head
);

	item_t             entries_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	logic              do_push;
	logic              do_pop;

	assign full       = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign head_valid = (count_q != '0);
	assign head       = entries_q[rd_ptr_q];
	assign do_push    = push && !full;
	assign do_pop     = pop && head_valid;

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + QPTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + QPTR_W'(1);
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + QCNT_W'(1);
				2'b01:   count_q <= count_q - QCNT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			entries_q[wr_ptr_q] <= push_item;
		end
	end

endmodule

// ----- src/rc6tx_back.sv -----
module rc6tx_back import rc6tx_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  cfg_t          cfg,
	input  logic          head_valid,
	input  item_t         head,
	output logic          pop,
	rc6tx_result_if.source results
);

	localparam int SEARCH_WIN = 5;

	// Frame state.
	logic [IDX_W-1:0]     idx_q;
	logic [LEN_W-1:0]     ticks_q;
	logic [6:0]           phase_q;
	logic [DATA_BITS-1:0] data_q;
	logic                 toggle_q;
	logic                 sending_q;
	logic                 is_mark_q;

	// Result register.
	logic out_valid_q;
	logic pin_q;
	logic busy_q;
	logic fend_q;
	logic rej_q;

	logic                 is_send;
	logic [DATA_BITS-1:0] dsrc;
	logic [CAND_W-1:0]    start;
	logic [CAND_W-1:0]    cand;
	len_sel_t             cand_sel;
	logic                 found;
	logic [CAND_W-1:0]    nxt_pos;
	len_sel_t             nxt_sel;
	logic [LEN_W-1:0]     nxt_len;
	logic                 nxt_mark;
	logic [LEN_W-1:0]     ticks_dec;
	logic [7:0]           phase_inc;
	logic [6:0]           phase_nxt;
	logic                 carrier_hi;
	logic                 pin_c;
	logic                 busy_c;
	logic                 fend_c;
	logic                 rej_c;

	function automatic logic [LEN_W-1:0] seg_len(input len_sel_t s, input cfg_t c);
		logic [LEN_W-1:0] len;
		case (s)
			LEN_LEADER:      len = c.leader_len;
			LEN_SHORT_MARK:  len = c.short_mark_len;
			LEN_TOGGLE_MARK: len = c.toggle_mark_len;
			LEN_SHORT_SPACE: len = LEN_W'(c.short_space);
			LEN_LONG_SPACE:  len = LEN_W'(c.long_space);
			default:         len = '0;
		endcase
		return len;
	endfunction

	assign is_send = (head.op == OP_SEND);
	assign pop     = head_valid && (!out_valid_q || results.ready);
	assign dsrc    = is_send ? head.data : data_q;
	assign start   = is_send ? '0 : CAND_W'(idx_q) + CAND_W'(1);

	// Next non-empty segment at or after start. While either half-bit length is
	// non-empty, one turns up within a short window; otherwise only the toggle
	// halves can remain.
	always_comb begin
		found    = 1'b0;
		nxt_pos  = '0;
		nxt_sel  = LEN_LEADER;
		cand     = '0;
		cand_sel = LEN_LEADER;
		for (int f = 1; f >= 0; f--) begin
			cand     = CAND_W'(TOGGLE_POS + f);
			cand_sel = seg_sel(cand, toggle_q, dsrc);
			if (cand >= start && seg_len(cand_sel, cfg) != '0) begin
				found   = 1'b1;
				nxt_pos = cand;
				nxt_sel = cand_sel;
			end
		end
		for (int w = SEARCH_WIN - 1; w >= 0; w--) begin
			cand     = start + CAND_W'(w);
			cand_sel = seg_sel(cand, toggle_q, dsrc);
			if (cand < CAND_W'(SEG_TOTAL) && seg_len(cand_sel, cfg) != '0) begin
				found   = 1'b1;
				nxt_pos = cand;
				nxt_sel = cand_sel;
			end
		end
	end

	assign nxt_len  = seg_len(nxt_sel, cfg);
	assign nxt_mark = (nxt_sel == LEN_LEADER) || (nxt_sel == LEN_SHORT_MARK)
		|| (nxt_sel == LEN_TOGGLE_MARK);

	// Carrier and tick countdown; the phase wraps at the current period.
	assign ticks_dec  = ticks_q - LEN_W'(1);
	assign carrier_hi = is_mark_q && (phase_q < {1'b0, cfg.half});
	assign phase_inc  = {1'b0, phase_q} + 8'd1;
	assign phase_nxt  = (phase_inc >= {1'b0, cfg.half, 1'b0}) ? '0 : phase_inc[6:0];

	// Result fields of the beat at the head.
	assign rej_c  = is_send && sending_q;
	assign busy_c = is_send || sending_q;
	assign pin_c  = !is_send && sending_q && (ticks_q != '0) && carrier_hi;
	assign fend_c = !is_send && sending_q
		&& ((ticks_q == '0) || ((ticks_dec == '0) && !found));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q     <= '0;
			ticks_q   <= '0;
			phase_q   <= '0;
			data_q    <= '0;
			toggle_q  <= 1'b0;
			sending_q <= 1'b0;
			is_mark_q <= 1'b0;
		end else if (pop) begin
			if (is_send && !sending_q) begin
				// Start a frame at its first non-empty segment.
				data_q    <= head.data;
				sending_q <= 1'b1;
				idx_q     <= found ? IDX_W'(nxt_pos) : IDX_W'(SEG_TOTAL);
				ticks_q   <= found ? nxt_len : '0;
				phase_q   <= '0;
				is_mark_q <= found && nxt_mark;
			end else if (!is_send && sending_q) begin
				if (fend_c) begin
					sending_q <= 1'b0;
					toggle_q  <= ~toggle_q;
					idx_q     <= '0;
					ticks_q   <= '0;
					phase_q   <= '0;
					is_mark_q <= 1'b0;
				end else if (ticks_dec == '0) begin
					idx_q     <= IDX_W'(nxt_pos);
					ticks_q   <= nxt_len;
					phase_q   <= '0;
					is_mark_q <= nxt_mark;
				end else begin
					ticks_q <= ticks_dec;
					phase_q <= phase_nxt;
				end
			end
		end
	end

	// Output register: a new result goes in while it is empty or as the old one leaves.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pop) begin
			out_valid_q <= 1'b1;
		end else if (results.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			pin_q  <= pin_c;
			busy_q <= busy_c;
			fend_q <= fend_c;
			rej_q  <= rej_c;
		end
	end

	assign results.valid     = out_valid_q;
	assign results.pin_level = pin_q;
	assign results.busy_res  = busy_q;
	assign results.frame_end = fend_q;
	assign results.rejected  = rej_q;

	// A running frame has an empty countdown only on its end marker.
	a_empty_only_at_end: assert property (@(posedge clk) disable iff (!arst_n)
		sending_q && (ticks_q == '0) |-> (idx_q == IDX_W'(SEG_TOTAL)))
		else $error("segment countdown empty before the end of the frame");

	// Between frames the segment state is clear.
	a_idle_clean: assert property (@(posedge clk) disable iff (!arst_n)
		!sending_q |-> (ticks_q == '0) && (phase_q == '0) && !is_mark_q)
		else $error("segment state left over after a frame");

	// The carrier shows only inside a frame.
	a_pin_in_frame: assert property (@(posedge clk) disable iff (!arst_n)
		results.valid && results.pin_level |-> results.busy_res)
		else $error("pin high outside a frame");

	// A rejected send is not a tick.
	a_reject_form: assert property (@(posedge clk) disable iff (!arst_n)
		results.valid && results.rejected
		|-> results.busy_res && !results.frame_end && !results.pin_level)
		else $error("rejected send carries tick fields");

endmodule

// ----- src/rc6_ir_frame_transmitter_unit.sv -----
// Channel    Dir  Beat                               Accepted when
// items      in   command, code[15:0]                items.valid && items.ready
// results    out  pin_level, busy_res, frame_end,    results.valid && results.ready
//                 rejected
// cfg_*      in   cfg_index[2:0], cfg_wdata[12:0]    cfg_we
//
// One item per clock sustained while results.ready holds; each item passes the input
// register, the queue and the segment sequencer with its output register.
// The segment sequencer updates the frame state once per item.
// Reset is asynchronous on arst_n and restores the register defaults.
// A stalled result fills the output register, then the two-entry queue and the
// input register before items.ready drops.
module rc6_ir_frame_transmitter_unit import rc6tx_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	rc6tx_item_if.sink            items,
	rc6tx_result_if.source        results
);

	cfg_t  cfg;
	logic  queue_full;
	logic  push;
	item_t push_item;
	logic  pop;
	logic  head_valid;
	item_t head;

	// Timing registers and quantized mark lengths.
	rc6tx_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	// Takes and classifies input beats.
	rc6tx_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.items      (items),
		.queue_full (queue_full),
		.push       (push),
		.push_item  (push_item)
	);

	rc6tx_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_item  (push_item),
		.full       (queue_full),
		.pop        (pop),
		.head_valid (head_valid),
		.head       (head)
	);

	// Walks the frame segments and drives the pin.
	rc6tx_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop),
		.results    (results)
	);

endmodule
